// ===== rtl/s2bc_pkg.sv =====
// Shared types, constants, round constant table and word functions for the SHA-2 compression block.
package s2bc_pkg;

  localparam int WORD_W       = 64;
  localparam int HALF_W       = 32;
  localparam int VARS         = 8;
  localparam int BLOCK_WORDS  = 16;
  localparam int ROUNDS_NARROW = 64;
  localparam int ROUNDS_WIDE  = 80;
  localparam int ROUND_W      = 7;
  localparam int IDX_W        = 3;
  localparam int CNT_W        = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [VARS-1:0] vars_t;
  typedef word_t [BLOCK_WORDS-1:0] window_t;

  // Request kinds.
  localparam logic REQ_CHAIN = 1'b0;
  localparam logic REQ_MSG   = 1'b1;

  // Word mode settings.
  localparam logic MODE_NARROW = 1'b0;
  localparam logic MODE_WIDE   = 1'b1;

  // Control bundle handed to the round datapath.
  typedef struct packed {
    logic wide;
  } round_ctrl_t;

  // Round constants for 64-bit words; the top halves of the first 64 are the 32-bit constants.
  localparam word_t K_ROM [ROUNDS_WIDE] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic word_t mask_word(word_t x, logic wide);
    return wide ? x : {{HALF_W{1'b0}}, x[HALF_W-1:0]};
  endfunction

  function automatic word_t rotr64(word_t x, int n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic word_t rotr32(word_t x, int n);
    logic [HALF_W-1:0] y;
    y = x[HALF_W-1:0];
    return {{HALF_W{1'b0}}, ((y >> n) | (y << (HALF_W - n)))};
  endfunction

  function automatic word_t big_sigma0(word_t x, logic wide);
    return wide ? (rotr64(x, 28) ^ rotr64(x, 34) ^ rotr64(x, 39))
                : (rotr32(x, 2) ^ rotr32(x, 13) ^ rotr32(x, 22));
  endfunction

  function automatic word_t big_sigma1(word_t x, logic wide);
    return wide ? (rotr64(x, 14) ^ rotr64(x, 18) ^ rotr64(x, 41))
                : (rotr32(x, 6) ^ rotr32(x, 11) ^ rotr32(x, 25));
  endfunction

  function automatic word_t small_sigma0(word_t x, logic wide);
    return wide ? (rotr64(x, 1) ^ rotr64(x, 8) ^ (x >> 7))
                : (rotr32(x, 7) ^ rotr32(x, 18) ^ (mask_word(x, 1'b0) >> 3));
  endfunction

  function automatic word_t small_sigma1(word_t x, logic wide);
    return wide ? (rotr64(x, 19) ^ rotr64(x, 61) ^ (x >> 6))
                : (rotr32(x, 17) ^ rotr32(x, 19) ^ (mask_word(x, 1'b0) >> 10));
  endfunction

endpackage

// ===== rtl/s2bc_if.sv =====
// Valid/ready channel interfaces for requests and hash results.
interface s2bc_req_if;
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [2:0]          word_index;
  s2bc_pkg::word_t     data_word;

  modport source (output valid, req_type, word_index, data_word, input ready);
  modport sink   (input valid, req_type, word_index, data_word, output ready);
endinterface

interface s2bc_rsp_if;
  logic                valid;
  logic                ready;
  s2bc_pkg::word_t     hash_word;
  logic [2:0]          hash_index;
  logic                last_word;

  modport source (output valid, hash_word, hash_index, last_word, input ready);
  modport sink   (input valid, hash_word, hash_index, last_word, output ready);
endinterface

// ===== rtl/s2bc_round.sv =====
// One SHA-2 round and one message schedule step, shared by every round of a block.
module s2bc_round (
  input  s2bc_pkg::round_ctrl_t ctrl,
  input  s2bc_pkg::vars_t       v,
  input  s2bc_pkg::word_t       k,
  input  s2bc_pkg::word_t       w0,
  input  s2bc_pkg::word_t       w1,
  input  s2bc_pkg::word_t       w9,
  input  s2bc_pkg::word_t       w14,
  output s2bc_pkg::vars_t       v_next,
  output s2bc_pkg::word_t       w_new
);

  s2bc_pkg::word_t t1;
  s2bc_pkg::word_t t2;
  s2bc_pkg::word_t ch;
  s2bc_pkg::word_t maj;

  always_comb begin
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1  = s2bc_pkg::mask_word(v[7] + s2bc_pkg::big_sigma1(v[4], ctrl.wide) + ch + k + w0,
                              ctrl.wide);
    t2  = s2bc_pkg::mask_word(s2bc_pkg::big_sigma0(v[0], ctrl.wide) + maj, ctrl.wide);

    v_next[7] = v[6];
    v_next[6] = v[5];
    v_next[5] = v[4];
    v_next[4] = s2bc_pkg::mask_word(v[3] + t1, ctrl.wide);
    v_next[3] = v[2];
    v_next[2] = v[1];
    v_next[1] = v[0];
    v_next[0] = s2bc_pkg::mask_word(t1 + t2, ctrl.wide);

    // Next schedule word, sixteen places ahead of the current one.
    w_new = s2bc_pkg::mask_word(s2bc_pkg::small_sigma1(w14, ctrl.wide) + w9
                                + s2bc_pkg::small_sigma0(w1, ctrl.wide) + w0, ctrl.wide);
  end

endmodule

// ===== rtl/sha2_block_compression_unit.sv =====
// Top level of the SHA-2 block compression unit: sequencer, state and result channel.
//
// Usage. Requests arrive on req (valid/ready). A request with req_type 0 loads
// chaining word word_index from data_word; a request with req_type 1 appends
// one big-endian message word to the current block. The sixteenth message
// word starts the compression in the mode held in the word_mode register
// (0: 32-bit words, 64 rounds; 1: 64-bit words, 80 rounds), written through
// cfg_we/cfg_wdata. The user must write it only while the unit is idle; the unit
// itself does not enforce this.
// Operation. Every request is taken while the unit is idle. After the
// sixteenth message word the unit is busy: one round per cycle through the
// shared round datapath, then the working variables are folded into the
// chaining value, then eight results a, b, .. h go out on rsp, the eighth
// flagged by last_word.
// Stalls. While rsp.ready is low the current result holds and no request is
// accepted. Reset clears the chaining value, the message word count, the
// round counter and the mode; the schedule window needs no clearing.
module sha2_block_compression_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  s2bc_req_if.sink          req,
  s2bc_rsp_if.source        rsp
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_FOLD  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t                                 state;
  logic                                   word_mode;
  s2bc_pkg::vars_t                        cv;
  s2bc_pkg::vars_t                        v;
  s2bc_pkg::vars_t                        v_next;
  s2bc_pkg::window_t                      win;
  s2bc_pkg::word_t                        w_new;
  s2bc_pkg::word_t                        k;
  logic [s2bc_pkg::CNT_W-1:0]             msg_cnt;
  logic [s2bc_pkg::ROUND_W-1:0]           round;
  logic [s2bc_pkg::IDX_W-1:0]             emit_idx;
  s2bc_pkg::round_ctrl_t                  ctrl;
  logic                                   req_acc;
  logic                                   rsp_acc;
  logic                                   wide;
  logic                                   last_round;

  assign wide       = (word_mode == s2bc_pkg::MODE_WIDE);
  assign ctrl.wide  = wide;
  assign req.ready  = (state == ST_IDLE);
  assign req_acc    = req.valid && req.ready;
  assign rsp_acc    = rsp.valid && rsp.ready;

  // In 32-bit mode the constant is the top half of the 64-bit one.
  assign k = wide ? s2bc_pkg::K_ROM[round]
                  : {{s2bc_pkg::HALF_W{1'b0}},
                     s2bc_pkg::K_ROM[round][s2bc_pkg::WORD_W-1:s2bc_pkg::HALF_W]};

  assign last_round = wide ? (round == s2bc_pkg::ROUND_W'(s2bc_pkg::ROUNDS_WIDE - 1))
                           : (round == s2bc_pkg::ROUND_W'(s2bc_pkg::ROUNDS_NARROW - 1));

  // The window shifts down by one word per round, so the round always reads
  // fixed taps: the current word at the bottom and its schedule inputs above.
  s2bc_round u_round (
    .ctrl   (ctrl),
    .v      (v),
    .k      (k),
    .w0     (win[0]),
    .w1     (win[1]),
    .w9     (win[9]),
    .w14    (win[14]),
    .v_next (v_next),
    .w_new  (w_new)
  );

  assign rsp.valid      = (state == ST_EMIT);
  assign rsp.hash_word  = cv[emit_idx];
  assign rsp.hash_index = emit_idx;
  assign rsp.last_word  = (emit_idx == s2bc_pkg::IDX_W'(s2bc_pkg::VARS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      word_mode <= s2bc_pkg::MODE_NARROW;
    end else if (cfg_we) begin
      word_mode <= cfg_wdata;
    end
  end

  // Control state and chaining value.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cv       <= '0;
      msg_cnt  <= '0;
      round    <= '0;
      emit_idx <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_acc) begin
            if (req.req_type == s2bc_pkg::REQ_CHAIN) begin
              cv[req.word_index] <= req.data_word;
            end else begin
              msg_cnt <= msg_cnt + 1'b1;
              if (msg_cnt == s2bc_pkg::CNT_W'(s2bc_pkg::BLOCK_WORDS - 1)) begin
                round <= '0;
                state <= ST_ROUND;
              end
            end
          end
        end
        ST_ROUND: begin
          if (last_round) begin
            round <= '0;
            state <= ST_FOLD;
          end else begin
            round <= round + 1'b1;
          end
        end
        ST_FOLD: begin
          for (int i = 0; i < s2bc_pkg::VARS; i++) begin
            cv[i] <= s2bc_pkg::mask_word(s2bc_pkg::mask_word(cv[i], wide) + v[i], wide);
          end
          emit_idx <= '0;
          state    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (rsp_acc) begin
            if (rsp.last_word) begin
              state <= ST_IDLE;
            end else begin
              emit_idx <= emit_idx + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: schedule window and working variables.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_acc && req.req_type == s2bc_pkg::REQ_MSG) begin
      win <= {req.data_word, win[s2bc_pkg::BLOCK_WORDS-1:1]};
      for (int i = 0; i < s2bc_pkg::VARS; i++) begin
        v[i] <= s2bc_pkg::mask_word(cv[i], wide);
      end
    end else if (state == ST_ROUND) begin
      win <= {w_new, win[s2bc_pkg::BLOCK_WORDS-1:1]};
      v   <= v_next;
    end
  end

  // A result is never offered while a request could be taken.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready)
    else $error("result offered while requests are accepted");

  // The round counter stays within the round count of the current mode.
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |->
      (round < (wide ? s2bc_pkg::ROUND_W'(s2bc_pkg::ROUNDS_WIDE)
                     : s2bc_pkg::ROUND_W'(s2bc_pkg::ROUNDS_NARROW))))
    else $error("round counter beyond round count");

  // Folding is followed by emission starting at word a.
  a_fold_then_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FOLD) |=> (state == ST_EMIT && emit_idx == '0))
    else $error("emission did not start at word a");

  // The message count only moves on an accepted message word.
  a_cnt_stable: assert property (@(posedge clk) disable iff (rst)
    !(req_acc && req.req_type == s2bc_pkg::REQ_MSG) |=> $stable(msg_cnt))
    else $error("message count changed without a message word");

endmodule
